FILE: hw/rtl/qnorm_pkg.sv
// Shared widths and types for the quaternion normalizer.
// No dependencies; all qnorm modules import this package.
`default_nettype none
package qnorm_pkg;
  localparam int CW     = 16;
  localparam int FB     = 14;
  localparam int SQ_W   = 2 * CW;
  localparam int SUM_W  = 2 * CW + 1;
  localparam int ROOT_W = CW + 1;
  localparam int Q_W    = FB + 1;
  localparam int DIVD_W = CW + FB;
  localparam int NCOMP  = 4;
  localparam logic [CW-1:0] ONE_RAW = CW'(1) << FB;

  typedef logic [CW-1:0] mag_t;
  typedef logic [Q_W-1:0] quo_t;

  typedef struct packed {
    logic [NCOMP-1:0]            neg;
    logic [NCOMP-1:0][CW-1:0]    mag;
    logic                        fb;
  } side_t;
endpackage
`default_nettype wire

FILE: hw/rtl/qnorm_sq.sv
// Magnitude, squaring and sum-of-squares stages (three registers).
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_sq import qnorm_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        vld_i,
  input  wire logic [NCOMP-1:0][CW-1:0]    comp_i,
  output logic                             vld_o,
  output logic [SUM_W-1:0]                 sum_o,
  output side_t                            side_o
);
  logic                       v1_r, v2_r, v3_r;
  side_t                      s1_r, s2_r, s3_r, s1_nxt;
  logic [NCOMP-1:0][SQ_W-1:0] sq_r;
  logic [SUM_W-1:0]           sum_r, sum_nxt;

  always_comb begin
    s1_nxt.fb = (comp_i == '0);
    for (int i = 0; i < NCOMP; i++) begin
      s1_nxt.neg[i] = comp_i[i][CW-1];
      s1_nxt.mag[i] = comp_i[i][CW-1] ? CW'(-comp_i[i]) : comp_i[i];
    end
    sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      for (int i = 0; i < NCOMP; i++) begin
        sq_r[i] <= s1_r.mag[i] * s1_r.mag[i];
      end
      s3_r  <= s2_r;
      sum_r <= sum_nxt;
    end
  end

  assign vld_o  = v3_r;
  assign sum_o  = sum_r;
  assign side_o = s3_r;
endmodule
`default_nettype wire

FILE: hw/rtl/qnorm_sqrt.sv
// Floor integer square root, one root bit per pipeline stage.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_sqrt import qnorm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);
  logic [ROOT_W-1:0]              vld_r;
  logic [ROOT_W-1:0][SUM_W-1:0]   rem_r;
  logic [ROOT_W-1:0][ROOT_W-1:0]  root_r;
  side_t                          side_r [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [SUM_W-1:0]  rem_in, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic [SUM_W:0]    trial;
    logic              vld_in;
    side_t             side_in;

    if (s == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign vld_in  = vld_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      trial    = ((SUM_W+1)'(root_in) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = SUM_W'({1'b0, rem_in} - trial);
        root_nxt = root_in | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];
endmodule
`default_nettype wire

FILE: hw/rtl/qnorm_div.sv
// Four-lane restoring divider, one quotient bit per pipeline stage.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_div import qnorm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire logic [ROOT_W-1:0]  norm_i,
  input  wire side_t              side_i,
  output logic                    vld_o,
  output quo_t [NCOMP-1:0]        quo_o,
  output side_t                   side_o
);
  logic [Q_W-1:0]                       vld_r;
  logic [Q_W-1:0][ROOT_W-1:0]           norm_r;
  side_t                                side_r [Q_W];
  logic [Q_W-1:0][NCOMP-1:0][DIVD_W-1:0] rem_r;
  logic [Q_W-1:0][NCOMP-1:0][Q_W-1:0]    quo_r;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic                           vld_in;
    logic [ROOT_W-1:0]              norm_in;
    side_t                          side_in;
    logic [NCOMP-1:0][DIVD_W-1:0]   rem_in, rem_nxt;
    logic [NCOMP-1:0][Q_W-1:0]      quo_in, quo_nxt;
    logic [DIVD_W:0]                dsr;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign norm_in = norm_i;
      assign side_in = side_i;
      for (genvar l = 0; l < NCOMP; l++) begin : g_ld
        assign rem_in[l] = DIVD_W'(side_i.mag[l]) << FB;
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign norm_in = norm_r[s-1];
      assign side_in = side_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
    end

    always_comb begin
      dsr = (DIVD_W+1)'(norm_in) << B;
      for (int l = 0; l < NCOMP; l++) begin
        rem_nxt[l] = rem_in[l];
        quo_nxt[l] = quo_in[l];
        if ({1'b0, rem_in[l]} >= dsr) begin
          rem_nxt[l] = DIVD_W'({1'b0, rem_in[l]} - dsr);
          quo_nxt[l] = quo_in[l] | (Q_W'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        norm_r[s] <= norm_in;
        side_r[s] <= side_in;
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
      end
    end
  end

  assign vld_o  = vld_r[Q_W-1];
  assign side_o = side_r[Q_W-1];
  for (genvar l = 0; l < NCOMP; l++) begin : g_out
    assign quo_o[l] = quo_r[Q_W-1][l];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_normalize.sv
// Quaternion normalizer top level: magnitude/square/sum, square root, divide, output register.
// Depends on qnorm_pkg, qnorm_sq, qnorm_sqrt, qnorm_div.
//
// Accepts one Q1.14 quaternion per cycle while in_stall is low and returns it scaled to unit
// length: three stages form the exact 33-bit sum of squares, 17 stages produce the floor
// square root one bit each, 15 stages divide all four components one quotient bit each, and
// one stage registers the signed result. An all-zero quaternion returns
// (1.0, 0, 0, 0) with out_fallback_used set. out_stall freezes the whole pipeline only while
// the output register holds an item; bubbles keep draining and in_stall follows it directly.
`default_nettype none
module quaternion_normalize import qnorm_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [CW-1:0] in_w_in,
  input  wire logic [CW-1:0] in_x_in,
  input  wire logic [CW-1:0] in_y_in,
  input  wire logic [CW-1:0] in_z_in,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [CW-1:0]      out_w_out,
  output logic [CW-1:0]      out_x_out,
  output logic [CW-1:0]      out_y_out,
  output logic [CW-1:0]      out_z_out,
  output logic               out_fallback_used
);
  logic                       en;
  logic                       sq_vld, rt_vld, dv_vld;
  logic [SUM_W-1:0]           sum;
  logic [ROOT_W-1:0]          root;
  side_t                      sq_side, rt_side, dv_side;
  quo_t [NCOMP-1:0]           quo;
  logic [NCOMP-1:0][CW-1:0]   comp, res_nxt;
  logic [NCOMP-1:0][CW-1:0]   res_r;
  logic                       out_valid_r, fb_r;

  assign in_stall = out_valid_r & out_stall;
  assign en       = ~in_stall;
  assign comp     = {in_z_in, in_y_in, in_x_in, in_w_in};

  qnorm_sq u_sq (
    .clk, .rst_n, .en,
    .vld_i  (in_valid),
    .comp_i (comp),
    .vld_o  (sq_vld),
    .sum_o  (sum),
    .side_o (sq_side)
  );

  qnorm_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .vld_i  (sq_vld),
    .sum_i  (sum),
    .side_i (sq_side),
    .vld_o  (rt_vld),
    .root_o (root),
    .side_o (rt_side)
  );

  qnorm_div u_div (
    .clk, .rst_n, .en,
    .vld_i  (rt_vld),
    .norm_i (root),
    .side_i (rt_side),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .side_o (dv_side)
  );

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      res_nxt[i] = dv_side.neg[i] ? CW'(-CW'(quo[i])) : CW'(quo[i]);
    end
    if (dv_side.fb) begin
      res_nxt    = '0;
      res_nxt[0] = ONE_RAW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      fb_r  <= dv_side.fb;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_w_out         = res_r[0];
  assign out_x_out         = res_r[1];
  assign out_y_out         = res_r[2];
  assign out_z_out         = res_r[3];
  assign out_fallback_used = fb_r;
endmodule
`default_nettype wire

FILE: hw/rtl/qnorm_chk.sv
// Port-level checker for quaternion_normalize, with its bind.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_chk import qnorm_pkg::*; (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic [CW-1:0] out_w_out,
  input wire logic [CW-1:0] out_x_out,
  input wire logic [CW-1:0] out_y_out,
  input wire logic [CW-1:0] out_z_out,
  input wire logic          out_fallback_used
);
  localparam logic [CW-1:0] NEG_ONE = CW'(-ONE_RAW);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_w_out) && $stable(out_z_out))
    else $error("stalled item changed");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output");

  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fallback_used |->
      out_w_out == ONE_RAW && out_x_out == '0 && out_y_out == '0 && out_z_out == '0)
    else $error("fallback item is not identity");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(out_w_out) <= $signed(ONE_RAW) && $signed(out_w_out) >= $signed(NEG_ONE)) &&
      ($signed(out_x_out) <= $signed(ONE_RAW) && $signed(out_x_out) >= $signed(NEG_ONE)))
    else $error("component beyond unit");
endmodule

bind quaternion_normalize qnorm_chk u_qnorm_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_w_out, .out_x_out, .out_y_out, .out_z_out, .out_fallback_used
);
`default_nettype wire
